FILE: hw/rtl/lmsdn_pkg.sv
// package: shared types, defaults and register indexes for the line enhancer
`timescale 1ns / 1ps
package lmsdn_pkg;

  localparam int MAX_TAPS_DEF  = 64;
  localparam int MAX_DELAY_DEF = 64;
  localparam int COEF_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [15:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_OUT_MODE     = 3'd1,
    REG_STEP_SIZE    = 3'd2,
    REG_LEAK_FACTOR  = 3'd3,
    REG_TAPS_LOG2    = 3'd4,
    REG_DELAY_LENGTH = 3'd5
  } reg_index_t;

  localparam logic [15:0] STEP_SIZE_RST    = 16'd655;
  localparam logic [15:0] LEAK_FACTOR_RST  = 16'd65535;
  localparam logic [2:0]  TAPS_LOG2_RST    = 3'd5;
  localparam logic [6:0]  DELAY_LENGTH_RST = 7'd1;

endpackage

FILE: hw/rtl/lmsdn_in_if.sv
// input channel: valid/ready with one audio sample
`timescale 1ns / 1ps
interface lmsdn_in_if import lmsdn_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

FILE: hw/rtl/lmsdn_out_if.sv
// output channel: valid/ready with one audio sample
`timescale 1ns / 1ps
interface lmsdn_out_if import lmsdn_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

FILE: hw/rtl/lmsdn_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module lmsdn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/lms_denoise_notch_filter.sv
// top level: leaky lms line enhancer / auto notch, one sample per word
// if disabled a word goes straight out; if enabled a leak step, a fir pass, an update pass
// one word at a time: a new word is taken only in idle, after the last one is handed
// out; two passes per word over the one-read-port coefficient ram, one multiply per cycle
// reset: synchronous; a pass over max(MAX_TAPS, MAX_DELAY) addresses zeroes all rams,
// no word is taken meanwhile; registers return to their reset values
`timescale 1ns / 1ps
module lms_denoise_notch_filter import lmsdn_pkg::*; #(
  parameter int MAX_TAPS  = MAX_TAPS_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lmsdn_in_if.sink              in_ch,
  lmsdn_out_if.source           out_ch
);
  localparam int CB      = COEF_BITS;
  localparam int TAW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNW     = TAW + 1;
  localparam int TL2_MAX = $clog2(MAX_TAPS + 1) - 1;
  localparam int DAW     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DLW0    = $clog2(MAX_DELAY + 1) + 1;
  localparam int LW      = (DLW0 > 8) ? DLW0 : 8;
  localparam int CLRN    = (MAX_TAPS > MAX_DELAY) ? MAX_TAPS : MAX_DELAY;
  localparam int CLW     = $clog2(CLRN + 1);
  localparam int AW0     = CB + 16 + TL2_MAX + 1;
  localparam int AW      = (AW0 > 40) ? AW0 : 40;
  localparam int PW      = AW - 20;
  localparam int SW      = ((CB > 23) ? CB : 23) + 1;
  localparam logic [63:0] CMAX64 = (64'd1 << (CB - 1)) - 64'd1;
  localparam logic signed [SW-1:0] CMAX = SW'(CMAX64);
  localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_LEAK_RD  = 11'b000_0000_0100,
    ST_LEAK_MUL = 11'b000_0000_1000,
    ST_LEAK_WR  = 11'b000_0001_0000,
    ST_FIR      = 11'b000_0010_0000,
    ST_FIN      = 11'b000_0100_0000,
    ST_KMUL     = 11'b000_1000_0000,
    ST_UPD      = 11'b001_0000_0000,
    ST_OUT      = 11'b010_0000_0000,
    ST_SPARE    = 11'b100_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic        enable, out_mode;
  logic [15:0] step_size, leak_factor;
  logic [2:0]  taps_log2;
  logic [6:0]  delay_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      out_mode     <= 1'b0;
      step_size    <= STEP_SIZE_RST;
      leak_factor  <= LEAK_FACTOR_RST;
      taps_log2    <= TAPS_LOG2_RST;
      delay_length <= DELAY_LENGTH_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ENABLE:       enable       <= cfg_data[0];
        REG_OUT_MODE:     out_mode     <= cfg_data[0];
        REG_STEP_SIZE:    step_size    <= cfg_data;
        REG_LEAK_FACTOR:  leak_factor  <= cfg_data;
        REG_TAPS_LOG2:    taps_log2    <= cfg_data[2:0];
        REG_DELAY_LENGTH: delay_length <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // derived sizes
  logic [2:0]     tl;
  logic [CNW-1:0] n;
  logic [TAW-1:0] mask;
  logic [LW-1:0]  d;

  always_comb begin
    tl   = ({1'b0, taps_log2} > 4'(TL2_MAX)) ? 3'(TL2_MAX) : taps_log2;
    n    = CNW'(1) << tl;
    mask = TAW'(n - CNW'(1));
    if (delay_length == 7'd0) begin
      d = LW'(1);
    end else if (LW'(delay_length) > LW'(MAX_DELAY)) begin
      d = LW'(MAX_DELAY);
    end else begin
      d = LW'(delay_length);
    end
  end

  // pointers
  logic [TAW-1:0] leak_index, tap_offset, li_q, to_q;
  logic [DAW-1:0] delay_pos, dp_eff, dp_next;
  logic [LW-1:0]  dp_inc;

  always_comb begin
    dp_eff  = (LW'(delay_pos) >= d) ? DAW'(0) : delay_pos;
    dp_inc  = LW'(dp_eff) + LW'(1);
    dp_next = (dp_inc >= d) ? DAW'(0) : DAW'(dp_inc);
  end

  // rams
  logic                          c_we, t_we, d_we;
  logic [TAW-1:0]                c_wa, c_ra, t_wa, t_ra;
  logic [DAW-1:0]                d_wa, d_ra;
  logic signed [CB-1:0]          c_wd, c_rd;
  sample_t                       t_wd, t_rd, d_wd, d_rd;

  lmsdn_ram #(.WIDTH(CB), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
  );
  lmsdn_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );
  lmsdn_ram #(.WIDTH(16), .DEPTH(MAX_DELAY)) u_delay_ram (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
  );

  // datapath registers
  sample_t                   x_q, y_q, err_q, pred_sat_q;
  logic [CLW-1:0]            clr_cnt;
  logic [CNW-1:0]            cnt;
  logic                      v1, v2;
  logic [TAW-1:0]            j1, j2;
  logic signed [CB+16:0]     leak_prod;
  logic signed [CB+15:0]     fir_prod;
  logic signed [AW-1:0]      acc;
  logic signed [32:0]        k;
  logic signed [48:0]        upd_prod;
  logic signed [CB-1:0]      coef_q;
  logic                      ov;
  sample_t                   oy;

  // combinational arithmetic
  logic signed [CB+16:0]     lk_sum;
  logic signed [CB-1:0]      leak_new;
  logic signed [AW-1:0]      acc_r;
  logic signed [PW-1:0]      pred;
  logic signed [PW:0]        diff;
  sample_t                   err_w, pred_sat_w;
  logic signed [48:0]        up_sum;
  logic signed [22:0]        delta;
  logic signed [SW-1:0]      nsum;
  logic signed [CB-1:0]      upd_new;
  logic                      issue;
  logic [TAW-1:0]            cidx;

  always_comb begin
    lk_sum   = leak_prod + (CB+17)'(32768);
    leak_new = lk_sum[CB+15:16];
    acc_r    = acc + AW'(524288);
    pred     = acc_r[AW-1:20];
    diff     = $signed({{(PW-15){x_q[15]}}, x_q}) - $signed({pred[PW-1], pred});
    if (diff > $signed((PW+1)'(32767))) begin
      err_w = 16'sh7fff;
    end else if (diff < -$signed((PW+1)'(32768))) begin
      err_w = -16'sh8000;
    end else begin
      err_w = diff[15:0];
    end
    if (pred > $signed(PW'(32767))) begin
      pred_sat_w = 16'sh7fff;
    end else if (pred < -$signed(PW'(32768))) begin
      pred_sat_w = -16'sh8000;
    end else begin
      pred_sat_w = pred[15:0];
    end
    up_sum = upd_prod + 49'sd33554432;
    delta  = up_sum[48:26];
    nsum   = $signed({{(SW-CB){coef_q[CB-1]}}, coef_q})
           + $signed({{(SW-23){delta[22]}}, delta});
    if (nsum > CMAX) begin
      upd_new = CMAX[CB-1:0];
    end else if (nsum < CMIN) begin
      upd_new = CMIN[CB-1:0];
    end else begin
      upd_new = nsum[CB-1:0];
    end
    issue = (cnt < n);
    cidx  = TAW'(cnt);
  end

  // ram port control
  always_comb begin
    c_we = 1'b0; c_wa = j2;   c_wd = upd_new; c_ra = cidx;
    t_we = 1'b0; t_wa = to_q; t_wd = d_rd;    t_ra = (cidx + to_q) & mask;
    d_we = 1'b0; d_wa = dp_eff; d_wd = x_q;   d_ra = delay_pos;
    case (state)
      ST_CLEAR: begin
        c_we = (clr_cnt < CLW'(MAX_TAPS));
        c_wa = TAW'(clr_cnt);
        c_wd = '0;
        t_we = c_we;
        t_wa = TAW'(clr_cnt);
        t_wd = '0;
        d_we = (clr_cnt < CLW'(MAX_DELAY));
        d_wa = DAW'(clr_cnt);
        d_wd = '0;
      end
      ST_LEAK_RD: begin
        c_ra = leak_index & mask;
        d_we = 1'b1;
      end
      ST_LEAK_WR: begin
        c_we = 1'b1;
        c_wa = li_q;
        c_wd = leak_new;
        t_we = 1'b1;
        t_wa = tap_offset & mask;
      end
      ST_UPD: begin
        c_we = v2;
      end
      default: ;
    endcase
  end

  assign in_ch.ready       = (state == ST_IDLE);
  assign out_ch.valid      = ov;
  assign out_ch.sample_out = oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      cnt        <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      ov         <= 1'b0;
      leak_index <= '0;
      tap_offset <= '0;
      delay_pos  <= '0;
    end else begin
      if (ov && out_ch.ready && (state != ST_OUT)) begin
        ov <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CLW'(1);
          if (clr_cnt == CLW'(CLRN - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            x_q <= in_ch.sample_in;
            y_q <= in_ch.sample_in;
            state <= enable ? ST_LEAK_RD : ST_OUT;
          end
        end
        ST_LEAK_RD: begin
          li_q      <= leak_index & mask;
          delay_pos <= dp_next;
          state     <= ST_LEAK_MUL;
        end
        ST_LEAK_MUL: begin
          leak_prod <= c_rd * $signed({1'b0, leak_factor});
          state     <= ST_LEAK_WR;
        end
        ST_LEAK_WR: begin
          leak_index <= (li_q + TAW'(1)) & mask;
          to_q       <= tap_offset & mask;
          acc        <= '0;
          cnt        <= '0;
          v1         <= 1'b0;
          v2         <= 1'b0;
          state      <= ST_FIR;
        end
        ST_FIR: begin
          if (issue) begin
            cnt <= cnt + CNW'(1);
          end
          v1 <= issue;
          v2 <= v1;
          if (v1) begin
            fir_prod <= c_rd * t_rd;
          end
          if (v2) begin
            acc <= acc + fir_prod;
          end
          if (!issue && !v1 && !v2) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          err_q      <= err_w;
          pred_sat_q <= pred_sat_w;
          state      <= ST_KMUL;
        end
        ST_KMUL: begin
          k     <= err_q * $signed({1'b0, step_size});
          cnt   <= '0;
          v1    <= 1'b0;
          v2    <= 1'b0;
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (issue) begin
            cnt <= cnt + CNW'(1);
          end
          v1 <= issue;
          v2 <= v1;
          j1 <= cidx;
          if (v1) begin
            upd_prod <= k * t_rd;
            coef_q   <= c_rd;
            j2       <= j1;
          end
          if (!issue && !v1 && !v2) begin
            tap_offset <= (to_q + TAW'(1)) & mask;
            y_q        <= out_mode ? err_q : pred_sat_q;
            state      <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!ov || out_ch.ready) begin
            ov    <= 1'b1;
            oy    <= y_q;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
